/* hw/rtl/lsfd_pkg.sv */
// Package with shared types, constants and helper functions for the LED strip frame driver.
`timescale 1ns / 1ps
package lsfd_pkg;

  localparam int unsigned MAX_LEDS      = 80;
  localparam int unsigned CHANNEL_COUNT = 8;
  localparam int unsigned STORE_DEPTH   = 240;
  localparam int unsigned MAX_COUNT     =
      (MAX_LEDS < STORE_DEPTH / 3) ? MAX_LEDS : STORE_DEPTH / 3;

  localparam int unsigned IDX_W     = $clog2(STORE_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = 2 * STORE_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ONE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ZERO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ZERO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ONE   = 2'd3;

  localparam logic [TICK_W-1:0] HIGH_ONE_RST  = 16'd16;
  localparam logic [TICK_W-1:0] HIGH_ZERO_RST = 16'd8;
  localparam logic [TICK_W-1:0] LOW_ZERO_RST  = 16'd17;
  localparam logic [TICK_W-1:0] LOW_ONE_RST   = 16'd1;

  typedef struct packed {
    logic [TICK_W-1:0] high_one;
    logic [TICK_W-1:0] high_zero;
    logic [TICK_W-1:0] low_zero;
    logic [TICK_W-1:0] low_one;
  } timing_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // Receiver state as it stands after the current byte, before any frame hand-over.
  typedef struct packed {
    logic             frame_ready;
    logic [7:0]       channel;
    logic [IDX_W-1:0] length;
    logic             bank;
  } rx_stat_t;

  typedef struct packed {
    logic [7:0] pins;
    logic       busy;
  } tx_res_t;

  // A programmed length of zero counts as one tick.
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  // Each buffer bank holds one frame; bank one sits above bank zero.
  function automatic logic [ADDR_W-1:0] mem_addr(input logic bank,
                                                 input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = bank ? ADDR_W'(STORE_DEPTH) : '0;
    return base + ADDR_W'(idx);
  endfunction

endpackage

/* hw/rtl/rgb_led_strip_frame_driver_top.sv */
// Top level of the eight-line RGB LED strip frame driver.
// Latency: the result of a transaction is registered and shown in the cycle after it is accepted.
// Throughput: one transaction per cycle while m_axis_tready does not stall the result,
// except that no input is taken while the transmitter reads each byte it starts (at frame
// start and after every eighth bit) from the frame buffer.
// Reset: control state and timing registers return to their defaults at once;
// the frame buffer is not cleared and holds nothing until written.
`timescale 1ns / 1ps
module rgb_led_strip_frame_driver_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
  input  logic                            s_axis_tuser,  // [0] mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] pin_levels, [8] busy_res, [9] frame_pending, [15:10] zero
  output logic [15:0]                     m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [lsfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsfd_pkg::TICK_W-1:0]     cfg_wdata_i
);

  lsfd_pkg::timing_t   timing_q;
  lsfd_pkg::rx_stat_t  rx_stat;
  lsfd_pkg::mem_wr_t   mem_wr;
  lsfd_pkg::tx_res_t   tx_res;
  logic                rd_en;
  logic [lsfd_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]          rd_data;
  logic                tx_active_post;
  logic                fetch;
  logic                step;
  logic                take;
  logic                out_valid_q;
  logic [15:0]         out_data_q;

  assign s_axis_tready = !fetch && (!out_valid_q || m_axis_tready);
  assign step          = s_axis_tvalid && s_axis_tready;
  assign take          = step && rx_stat.frame_ready && !tx_active_post;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.high_one  <= lsfd_pkg::HIGH_ONE_RST;
      timing_q.high_zero <= lsfd_pkg::HIGH_ZERO_RST;
      timing_q.low_zero  <= lsfd_pkg::LOW_ZERO_RST;
      timing_q.low_one   <= lsfd_pkg::LOW_ONE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsfd_pkg::REG_HIGH_ONE:  timing_q.high_one  <= cfg_wdata_i;
        lsfd_pkg::REG_HIGH_ZERO: timing_q.high_zero <= cfg_wdata_i;
        lsfd_pkg::REG_LOW_ZERO:  timing_q.low_zero  <= cfg_wdata_i;
        lsfd_pkg::REG_LOW_ONE:   timing_q.low_one   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lsfd_rx u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (step && !s_axis_tuser),
    .byte_i       (s_axis_tdata),
    .take_i       (take),
    .stat_o       (rx_stat),
    .wr_o         (mem_wr)
  );

  lsfd_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lsfd_tx u_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (step && s_axis_tuser),
    .take_i        (take),
    .rx_i          (rx_stat),
    .timing_i      (timing_q),
    .rd_data_i     (rd_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .active_post_o (tx_active_post),
    .fetch_o       (fetch),
    .res_o         (tx_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {6'd0, rx_stat.frame_ready && !take, tx_res.busy, tx_res.pins};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/lsfd_mem.sv */
// Frame buffer memory: two banks, one write port and one registered read port.
`timescale 1ns / 1ps
module lsfd_mem (
  input  logic                         clk_i,
  input  lsfd_pkg::mem_wr_t            wr_i,
  input  logic                         rd_en_i,
  input  logic [lsfd_pkg::ADDR_W-1:0]  rd_addr_i,
  output logic [7:0]                   rd_data_o
);

  logic [7:0] mem_q [lsfd_pkg::MEM_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/lsfd_rx.sv */
// Command receiver: parses channel, LED count and colour bytes into the receive bank.
`timescale 1ns / 1ps
module lsfd_rx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           byte_i,
  input  logic                 take_i,
  output lsfd_pkg::rx_stat_t   stat_o,
  output lsfd_pkg::mem_wr_t    wr_o
);

  typedef enum logic [1:0] {
    PH_CHANNEL = 2'd0,
    PH_COUNT   = 2'd1,
    PH_DATA    = 2'd2
  } rx_phase_e;

  rx_phase_e                      phase_q, phase_d;
  logic [7:0]                     channel_q, channel_d;
  logic [lsfd_pkg::IDX_W-1:0]     length_q, length_d;
  logic [lsfd_pkg::IDX_W-1:0]     pos_q, pos_d;
  logic [lsfd_pkg::IDX_W-1:0]     pos_inc;
  logic [lsfd_pkg::IDX_W-1:0]     count;
  logic                           ready_q, ready_d;
  logic                           bank_q, bank_d;
  logic                           ready_post;
  logic [lsfd_pkg::IDX_W-1:0]     length_post;

  assign pos_inc = pos_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    channel_d = channel_q;
    length_d  = length_q;
    pos_d     = pos_q;
    ready_d   = ready_q;
    bank_d    = bank_q;
    wr_o      = '0;
    count     = (byte_i > 8'(lsfd_pkg::MAX_COUNT)) ?
                lsfd_pkg::IDX_W'(lsfd_pkg::MAX_COUNT) : lsfd_pkg::IDX_W'(byte_i);

    if (byte_valid_i && !ready_q) begin
      unique case (phase_q)
        PH_CHANNEL: begin
          channel_d = byte_i;
          phase_d   = PH_COUNT;
        end
        PH_COUNT: begin
          length_d = (count << 1) + count;
          pos_d    = '0;
          phase_d  = PH_DATA;
          ready_d  = (length_d == '0);
        end
        default: begin
          wr_o.en   = (pos_q < lsfd_pkg::IDX_W'(lsfd_pkg::STORE_DEPTH));
          wr_o.addr = lsfd_pkg::mem_addr(bank_q, pos_q);
          wr_o.data = byte_i;
          pos_d     = pos_inc;
          ready_d   = (pos_inc >= length_q);
        end
      endcase
    end

    ready_post  = ready_d;
    length_post = length_d;

    // The transmitter takes the finished bank and the receiver moves to the other one.
    if (take_i) begin
      ready_d = 1'b0;
      phase_d = PH_CHANNEL;
      pos_d   = '0;
      bank_d  = ~bank_q;
    end
  end

  assign stat_o.frame_ready = ready_post;
  assign stat_o.channel     = channel_d;
  assign stat_o.length      = length_post;
  assign stat_o.bank        = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CHANNEL;
      channel_q <= '0;
      length_q  <= '0;
      pos_q     <= '0;
      ready_q   <= 1'b0;
      bank_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      channel_q <= channel_d;
      length_q  <= length_d;
      pos_q     <= pos_d;
      ready_q   <= ready_d;
      bank_q    <= bank_d;
    end
  end

endmodule

/* hw/rtl/lsfd_tx.sv */
// Pulse transmitter: walks the transmit bank bit by bit and times the high and low phases.
`timescale 1ns / 1ps
module lsfd_tx (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          take_i,
  input  lsfd_pkg::rx_stat_t            rx_i,
  input  lsfd_pkg::timing_t             timing_i,
  input  logic [7:0]                    rd_data_i,
  output logic                          rd_en_o,
  output logic [lsfd_pkg::ADDR_W-1:0]   rd_addr_o,
  output logic                          active_post_o,
  output logic                          fetch_o,
  output lsfd_pkg::tx_res_t             res_o
);

  logic                          active_q, active_d;
  logic                          high_q, high_d;
  logic [2:0]                    channel_q, channel_d;
  logic [lsfd_pkg::IDX_W-1:0]    length_q, length_d;
  logic [lsfd_pkg::IDX_W-1:0]    byte_idx_q, byte_idx_d;
  logic [lsfd_pkg::IDX_W-1:0]    byte_next;
  logic [lsfd_pkg::IDX_W-1:0]    rd_idx;
  logic [2:0]                    bit_idx_q, bit_idx_d;
  logic [lsfd_pkg::TICK_W-1:0]   timer_q, timer_d;
  logic                          bank_q, bank_d;
  logic [7:0]                    cur_byte_q, cur_byte_d;
  logic                          fetch_q, fetch_d;
  logic                          bit_now;
  logic                          bit_after;

  assign byte_next = byte_idx_q + 1'b1;
  assign bit_now   = cur_byte_q[bit_idx_q];
  assign bit_after = cur_byte_q[bit_idx_q - 3'd1];

  always_comb begin
    active_d   = active_q;
    high_d     = high_q;
    channel_d  = channel_q;
    length_d   = length_q;
    byte_idx_d = byte_idx_q;
    bit_idx_d  = bit_idx_q;
    timer_d    = timer_q;
    bank_d     = bank_q;
    cur_byte_d = cur_byte_q;
    fetch_d    = 1'b0;
    rd_en_o    = 1'b0;
    rd_idx     = byte_next;

    // A new byte has arrived from the buffer; its top bit sets the high phase length.
    if (fetch_q) begin
      cur_byte_d = rd_data_i;
      timer_d    = lsfd_pkg::at_least_one(rd_data_i[7] ? timing_i.high_one :
                                                         timing_i.high_zero);
    end

    if (tick_i && active_q) begin
      if (timer_q > lsfd_pkg::TICK_W'(1)) begin
        timer_d = timer_q - 1'b1;
      end else if (high_q) begin
        high_d  = 1'b0;
        timer_d = lsfd_pkg::at_least_one(bit_now ? timing_i.low_one :
                                                   timing_i.low_zero);
      end else if (bit_idx_q != 3'd0) begin
        bit_idx_d = bit_idx_q - 3'd1;
        high_d    = 1'b1;
        timer_d   = lsfd_pkg::at_least_one(bit_after ? timing_i.high_one :
                                                       timing_i.high_zero);
      end else begin
        bit_idx_d  = 3'd7;
        byte_idx_d = byte_next;
        if (byte_next >= length_q) begin
          active_d = 1'b0;
          timer_d  = '0;
        end else begin
          high_d  = 1'b1;
          fetch_d = 1'b1;
          rd_en_o = 1'b1;
        end
      end
    end

    active_post_o = active_d;

    if (take_i) begin
      channel_d  = rx_i.channel[2:0];
      length_d   = rx_i.length;
      bank_d     = rx_i.bank;
      byte_idx_d = '0;
      bit_idx_d  = 3'd7;
      high_d     = 1'b0;
      timer_d    = '0;
      active_d   = (rx_i.channel < 8'(lsfd_pkg::CHANNEL_COUNT)) && (rx_i.length != '0);
      if (active_d) begin
        high_d  = 1'b1;
        fetch_d = 1'b1;
        rd_en_o = 1'b1;
        rd_idx  = '0;
      end
    end
  end

  assign rd_addr_o  = lsfd_pkg::mem_addr(take_i ? rx_i.bank : bank_q, rd_idx);
  assign fetch_o    = fetch_q;
  assign res_o.busy = active_d;
  assign res_o.pins = (active_d && high_d) ? (8'd1 << channel_d) : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      high_q     <= 1'b0;
      channel_q  <= '0;
      length_q   <= '0;
      byte_idx_q <= '0;
      bit_idx_q  <= 3'd7;
      timer_q    <= '0;
      bank_q     <= 1'b0;
      fetch_q    <= 1'b0;
    end else begin
      active_q   <= active_d;
      high_q     <= high_d;
      channel_q  <= channel_d;
      length_q   <= length_d;
      byte_idx_q <= byte_idx_d;
      bit_idx_q  <= bit_idx_d;
      timer_q    <= timer_d;
      bank_q     <= bank_d;
      fetch_q    <= fetch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_byte_q <= cur_byte_d;
  end

endmodule

/* hw/rtl/lsfd_checker.sv */
// Port-level checker for the LED strip frame driver, bound to the top level.
`timescale 1ns / 1ps
module lsfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A result that is not taken stays as it is.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Every accepted transaction produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted transaction gave no result");

  // At most one line is driven, and only while a frame is being sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[7:0]) &&
                      ((m_axis_tdata[7:0] == 8'd0) || m_axis_tdata[8]))
    else $error("pin levels inconsistent with busy state");

  // A finished frame only waits while the transmitter is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8])
    else $error("frame pending while transmitter idle");

endmodule

bind rgb_led_strip_frame_driver_top lsfd_checker u_lsfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* test/rgb_led_strip_checker.sv */
// Checker that predicts the LED strip driver's results and compares them with its output stream.
`timescale 1ns / 1ps
module rgb_led_strip_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  input  logic                           s_axis_tuser,  // [0] mode
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] pin_levels, [8] busy_res, [9] frame_pending, [15:10] zero
  input  logic [15:0]                    m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [lsfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsfd_pkg::TICK_W-1:0]    cfg_wdata_i,
  output int                             mismatches_o,
  output int                             outstanding_o,
  output int                             effective_items_o,
  output int                             results_seen_o,
  output logic                           tx_busy_o,
  output logic                           frame_waiting_o
);

  localparam int unsigned DEPTH = lsfd_pkg::STORE_DEPTH;

  typedef enum logic [1:0] {WAIT_CHANNEL, WAIT_COUNT, WAIT_COLOUR} rx_step_e;

  typedef struct packed {
    logic [7:0] pins;
    logic       busy;
    logic       pending;
  } strip_levels_t;

  logic [15:0]   high_one_len, high_zero_len, low_zero_len, low_one_len;
  rx_step_e      rx_step;
  logic [7:0]    rx_chan, rx_len, rx_pos;
  logic [7:0]    rx_buf [DEPTH];
  logic          frame_done;
  logic [7:0]    tx_buf [DEPTH];
  logic [2:0]    tx_chan;
  logic [7:0]    tx_len, byte_idx;
  logic [2:0]    bit_idx;
  logic          in_high, sending;
  logic [15:0]   ticks_left;
  strip_levels_t predicted_levels_q [$];

  function automatic logic [15:0] ticks_of(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic tx_bit();
    logic [7:0] b;
    b = (byte_idx < DEPTH) ? tx_buf[byte_idx] : 8'h00;
    return b[bit_idx];
  endfunction

  task automatic start_high();
    in_high    = 1'b1;
    ticks_left = ticks_of(tx_bit() ? high_one_len : high_zero_len);
  endtask

  task automatic clear_model();
    high_one_len  = lsfd_pkg::HIGH_ONE_RST;
    high_zero_len = lsfd_pkg::HIGH_ZERO_RST;
    low_zero_len  = lsfd_pkg::LOW_ZERO_RST;
    low_one_len   = lsfd_pkg::LOW_ONE_RST;
    rx_step       = WAIT_CHANNEL;
    rx_chan       = '0;
    rx_len        = '0;
    rx_pos        = '0;
    frame_done    = 1'b0;
    tx_chan       = '0;
    tx_len        = '0;
    byte_idx      = '0;
    bit_idx       = 3'd7;
    in_high       = 1'b0;
    ticks_left    = '0;
    sending       = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      rx_buf[i] = '0;
      tx_buf[i] = '0;
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    int unsigned leds;
    if (frame_done) return;
    case (rx_step)
      WAIT_CHANNEL: begin
        rx_chan = b;
        rx_step = WAIT_COUNT;
      end
      WAIT_COUNT: begin
        leds    = (b > lsfd_pkg::MAX_COUNT) ? lsfd_pkg::MAX_COUNT : b;
        rx_len  = 8'(leds * 3);
        rx_pos  = '0;
        rx_step = WAIT_COLOUR;
        if (rx_len == 8'd0) frame_done = 1'b1;
      end
      default: begin
        if (rx_pos < DEPTH) rx_buf[rx_pos] = b;
        rx_pos = rx_pos + 8'd1;
        if (rx_pos >= rx_len) frame_done = 1'b1;
      end
    endcase
  endtask

  task automatic take_tick();
    logic b;
    if (!sending) return;
    if (ticks_left > 16'd1) begin
      ticks_left = ticks_left - 16'd1;
      return;
    end
    b = tx_bit();
    if (in_high) begin
      in_high    = 1'b0;
      ticks_left = ticks_of(b ? low_one_len : low_zero_len);
      return;
    end
    if (bit_idx > 3'd0) begin
      bit_idx = bit_idx - 3'd1;
    end else begin
      bit_idx  = 3'd7;
      byte_idx = byte_idx + 8'd1;
      if (byte_idx >= tx_len) begin
        sending    = 1'b0;
        ticks_left = '0;
        return;
      end
    end
    start_high();
  endtask

  // The transmitter takes a finished frame as soon as it has nothing left to send.
  task automatic hand_over();
    tx_buf     = rx_buf;
    tx_len     = rx_len;
    tx_chan    = rx_chan[2:0];
    byte_idx   = '0;
    bit_idx    = 3'd7;
    in_high    = 1'b0;
    ticks_left = '0;
    sending    = (rx_chan < lsfd_pkg::CHANNEL_COUNT) && (tx_len > 8'd0);
    if (sending) start_high();
    frame_done = 1'b0;
    rx_step    = WAIT_CHANNEL;
    rx_pos     = '0;
  endtask

  task automatic advance_strip(input logic mode, input logic [7:0] b,
                               output strip_levels_t levels);
    if (mode) take_tick();
    else take_byte(b);
    if (!sending && frame_done) hand_over();
    levels.pins    = (sending && in_high) ? (8'd1 << tx_chan) : 8'd0;
    levels.busy    = sending;
    levels.pending = frame_done;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    strip_levels_t want, got;
    if (!rst_ni) begin
      clear_model();
      predicted_levels_q.delete();
      mismatches_o      = 0;
      outstanding_o     = 0;
      effective_items_o = 0;
      results_seen_o    = 0;
      tx_busy_o         = 1'b0;
      frame_waiting_o   = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lsfd_pkg::REG_HIGH_ONE:  high_one_len  = cfg_wdata_i;
          lsfd_pkg::REG_HIGH_ZERO: high_zero_len = cfg_wdata_i;
          lsfd_pkg::REG_LOW_ZERO:  low_zero_len  = cfg_wdata_i;
          lsfd_pkg::REG_LOW_ONE:   low_one_len   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        // Ticks on an idle line and bytes behind a waiting frame change nothing.
        if (s_axis_tuser ? sending : !frame_done) effective_items_o++;
        advance_strip(s_axis_tuser, s_axis_tdata, want);
        predicted_levels_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.pins    = m_axis_tdata[7:0];
        got.busy    = m_axis_tdata[8];
        got.pending = m_axis_tdata[9];
        results_seen_o++;
        if (predicted_levels_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: unexpected result pins %02h busy %b pending %b",
                     $realtime, got.pins, got.busy, got.pending);
        end else begin
          want = predicted_levels_q.pop_front();
          if (want.pins !== got.pins || want.busy !== got.busy ||
              want.pending !== got.pending) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: pins exp %02h got %02h, busy exp %b got %b, pending exp %b got %b",
                       $realtime, want.pins, got.pins, want.busy, got.busy,
                       want.pending, got.pending);
          end
        end
      end
      outstanding_o   = predicted_levels_q.size();
      tx_busy_o       = sending;
      frame_waiting_o = frame_done;
    end
  end

endmodule

/* test/rgb_led_strip_frame_driver_top_test.sv */
// Testbench top for the LED strip frame driver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module rgb_led_strip_frame_driver_top_test;

  localparam int PHASE_ITEMS = 200;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b1;
  logic [15:0]                    m_tdata;
  logic                           cfg_we = 1'b0;
  logic [lsfd_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [lsfd_pkg::TICK_W-1:0]    cfg_wdata = '0;

  int   mismatches, outstanding, effective_items, results_seen;
  logic tx_busy, frame_waiting;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   bytes_sent = 0;
  int   ticks_sent = 0;
  int   frames_sent = 0;
  logic [7:0] colour_bytes [lsfd_pkg::STORE_DEPTH];

  rgb_led_strip_frame_driver_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  rgb_led_strip_checker u_strip_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .s_axis_tvalid     (s_tvalid),
    .s_axis_tready     (s_tready),
    .s_axis_tdata      (s_tdata),
    .s_axis_tuser      (s_tuser),
    .m_axis_tvalid     (m_tvalid),
    .m_axis_tready     (m_tready),
    .m_axis_tdata      (m_tdata),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .mismatches_o      (mismatches),
    .outstanding_o     (outstanding),
    .effective_items_o (effective_items),
    .results_seen_o    (results_seen),
    .tx_busy_o         (tx_busy),
    .frame_waiting_o   (frame_waiting)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Every task starts and ends at a falling edge, so each input changes once per cycle.
  task automatic send_item(input logic mode, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (mode) ticks_sent++;
    else bytes_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic fill_colours(input int n);
    for (int i = 0; i < n; i++) colour_bytes[i] = 8'($urandom_range(255));
  endtask

  task automatic send_frame(input logic [7:0] chan, input logic [7:0] count,
                            input int n_data, input int tick_pct);
    send_item(1'b0, chan);
    send_item(1'b0, count);
    for (int i = 0; i < n_data; i++) begin
      send_item(1'b0, colour_bytes[i]);
      if ($urandom_range(99) < tick_pct) send_ticks($urandom_range(1, 12));
    end
    frames_sent++;
  endtask

  task automatic pause_sender();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Ticks until the line has gone quiet and no frame waits, then drains the results.
  task automatic settle();
    while (tx_busy || frame_waiting) send_item(1'b1, 8'($urandom_range(255)));
    pause_sender();
  endtask

  task automatic write_timing(input logic [15:0] high_one, input logic [15:0] high_zero,
                              input logic [15:0] low_zero, input logic [15:0] low_one);
    cfg_we    <= 1'b1;
    cfg_idx   <= lsfd_pkg::REG_HIGH_ONE;
    cfg_wdata <= high_one;
    @(negedge clk);
    cfg_idx   <= lsfd_pkg::REG_HIGH_ZERO;
    cfg_wdata <= high_zero;
    @(negedge clk);
    cfg_idx   <= lsfd_pkg::REG_LOW_ZERO;
    cfg_wdata <= low_zero;
    @(negedge clk);
    cfg_idx   <= lsfd_pkg::REG_LOW_ONE;
    cfg_wdata <= low_one;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_frame();
    logic [7:0] chan, count;
    int         sel, n_data;
    logic       broken;
    // Mostly let a waiting frame go out first, so that the next one is not dropped.
    if ($urandom_range(99) < 70)
      while (frame_waiting) send_item(1'b1, 8'($urandom_range(255)));
    chan = ($urandom_range(99) < 88) ? 8'($urandom_range(7)) : 8'($urandom_range(255, 8));
    sel  = $urandom_range(99);
    if (sel < 10) begin
      count = 8'd0;
    end else if (sel < 94) begin
      count = 8'($urandom_range(3, 1));
    end else if (sel < 98) begin
      count = 8'($urandom_range(12, 4));
    end else begin
      // Oversized counts go to an absent line to keep the run short.
      count = 8'($urandom_range(255, 81));
      chan  = 8'($urandom_range(255, 8));
    end
    n_data = (count > lsfd_pkg::MAX_COUNT) ? lsfd_pkg::MAX_COUNT * 3 : count * 3;
    broken = ($urandom_range(99) < 8);
    if (broken) n_data = $urandom_range(n_data);
    fill_colours(n_data);
    send_frame(chan, count, n_data, 35);
    if (broken) repeat ($urandom_range(3, 1)) send_item(1'b0, 8'($urandom_range(255)));
    if ($urandom_range(99) < 40) send_ticks($urandom_range(60, 1));
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input logic with_pause);
    int   start;
    logic paused;
    settle();
    write_timing(16'($urandom_range(3)), 16'($urandom_range(3)),
                 16'($urandom_range(3)), 16'($urandom_range(3)));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start  = effective_items;
    paused = 1'b0;
    while (effective_items - start < PHASE_ITEMS) begin
      random_frame();
      if (with_pause && !paused && effective_items - start > PHASE_ITEMS / 2) begin
        pause_sender();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Ticks with nothing to send.
    send_ticks(3);
    colour_bytes[0] = 8'hA5;
    colour_bytes[1] = 8'h5A;
    colour_bytes[2] = 8'hC3;
    send_frame(8'd0, 8'd1, 3, 0);
    send_ticks(5);
    // A second frame completes while the first is on the line; the bytes after it are lost.
    colour_bytes[0] = 8'hFF;
    colour_bytes[1] = 8'h00;
    colour_bytes[2] = 8'h81;
    send_frame(8'd7, 8'd1, 3, 0);
    repeat (3) send_item(1'b0, 8'h3C);
    settle();

    send_frame(8'd3, 8'd0, 0, 0);
    fill_colours(3);
    send_frame(8'd8, 8'd1, 3, 0);
    send_frame(8'd255, 8'd0, 0, 0);
    send_ticks(4);
    settle();

    // Zero lengths behave as one tick.
    write_timing(16'd0, 16'd0, 16'd0, 16'd0);
    fill_colours(6);
    send_frame(8'd5, 8'd2, 6, 50);
    settle();
    // Counts beyond the store size saturate.
    fill_colours(lsfd_pkg::STORE_DEPTH);
    send_frame(8'd9, 8'd81, lsfd_pkg::MAX_COUNT * 3, 0);
    settle();

    // Long phases, each reached by a single bit.
    write_timing(16'd40, 16'd1, 16'd0, 16'd40);
    colour_bytes[0] = 8'h80;
    colour_bytes[1] = 8'h00;
    colour_bytes[2] = 8'h00;
    send_frame(8'd6, 8'd1, 3, 0);
    settle();
    write_timing(16'd0, 16'd40, 16'd40, 16'd1);
    colour_bytes[0] = 8'hFF;
    colour_bytes[1] = 8'hFF;
    colour_bytes[2] = 8'hFE;
    send_frame(8'd1, 8'd1, 3, 0);
    settle();

    random_phase(0, 0, 1'b0);
    random_phase(54, 0, 1'b1);
    random_phase(0, 54, 1'b0);
    random_phase(11, 11, 1'b0);
    settle();
    repeat (20) @(negedge clk);

    $display("Sent %0d command bytes and %0d ticks in %0d frames across eight timing setups",
             bytes_sent, ticks_sent, frames_sent);
    $display("and four flow-control mixes; %0d results checked, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
